[src/tpm_pkg.sv]
// Shared types, constants and helper functions for the trapezoidal point mover.
// Depends on nothing; tpm_core, the top level and the testbench import it.
`default_nettype none

package tpm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIR_FRAC  = 14;
    localparam int DT_FRAC   = 16;

    localparam logic [31:0] ACCEL_RESET       = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] SPEED_LIMIT_RESET = 32'(64'd10 << FRAC_BITS);
    localparam logic [15:0] DIR_ONE           = 16'(32'd1 << DIR_FRAC);

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_SET_EYE  = 3'd1;
    localparam logic [2:0] OP_SET_AIM  = 3'd2;
    localparam logic [2:0] OP_ZOOM_IN  = 3'd3;
    localparam logic [2:0] OP_ZOOM_OUT = 3'd4;

    localparam logic REG_ACCEL       = 1'b0;
    localparam logic REG_SPEED_LIMIT = 1'b1;

    localparam logic PT_EYE = 1'b0;
    localparam logic PT_AIM = 1'b1;

    typedef struct packed {
        logic [2:0]         op;
        logic [15:0]        dt;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               keep_offset;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] aim_x;
        logic signed [31:0] aim_y;
        logic signed [31:0] aim_z;
        logic               moving;
    } res_t;

    // Saturates a 35-bit signed value to 32 bits.
    function automatic logic [31:0] sat32(input logic [34:0] v);
        logic [31:0] r;
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
            r = v[31:0];
        end else if (v[34]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [34:0] sext35(input logic [31:0] v);
        return {{3{v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

[src/tpm_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`default_nettype none

module tpm_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [33:0] den,
    output logic             done,
    output logic [63:0]      quo
);

    logic [33:0] rem_reg, rem_next;
    logic [63:0] num_reg, num_next;
    logic [33:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [34:0] shifted;
    logic        fits;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[63]};
        fits      = shifted >= {1'b0, den_reg};
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            num_next = num;
            den_next = den;
            cnt_next = 6'd63;
            run_next = 1'b1;
        end else if (run_reg)
        begin
            rem_next = fits ? 34'(shifted - {1'b0, den_reg}) : shifted[33:0];
            num_next = {num_reg[62:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

`default_nettype wire

[src/tpm_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
// Depends on nothing outside this file.
`default_nettype none

module tpm_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic [33:0] rem_reg, rem_next;
    logic [63:0] x_reg, x_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [35:0] shifted;
    logic [33:0] trial;
    logic        fits;

    always_comb
    begin
        shifted   = {rem_reg, x_reg[63:62]};
        trial     = {root_reg, 2'b01};
        fits      = shifted >= {2'b00, trial};
        rem_next  = rem_reg;
        x_next    = x_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            x_next    = radicand;
            root_next = '0;
            cnt_next  = 5'd31;
            run_next  = 1'b1;
        end else if (run_reg)
        begin
            rem_next  = fits ? 34'(shifted - {2'b00, trial}) : shifted[33:0];
            x_next    = {x_reg[61:0], 2'b00};
            root_next = {root_reg[30:0], fits};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        x_reg    <= x_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[src/tpm_core.sv]
// Sequencer, motion state and shared multiplier of the point mover.
// Depends on tpm_pkg, tpm_div and tpm_sqrt.
`default_nettype none

module tpm_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [31:0]   accel,
    input  wire logic [31:0]   speed_limit,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire tpm_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_ready,
    output tpm_pkg::res_t      res
);
    import tpm_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_LEN_SHIFT = 5'd2;
    localparam logic [4:0] S_LEN_SQ   = 5'd3;
    localparam logic [4:0] S_LEN_ROOT = 5'd4;
    localparam logic [4:0] S_LEN_WAIT = 5'd5;
    localparam logic [4:0] S_TK_DV    = 5'd6;
    localparam logic [4:0] S_TK_VV    = 5'd7;
    localparam logic [4:0] S_TK_DIV   = 5'd8;
    localparam logic [4:0] S_TK_DIVW  = 5'd9;
    localparam logic [4:0] S_TK_SPEED = 5'd10;
    localparam logic [4:0] S_TK_STEP  = 5'd11;
    localparam logic [4:0] S_TK_SNAP  = 5'd12;
    localparam logic [4:0] S_TK_MUL   = 5'd13;
    localparam logic [4:0] S_TK_ADD   = 5'd14;
    localparam logic [4:0] S_DIR_CALC = 5'd15;
    localparam logic [4:0] S_DIR_WAIT = 5'd16;
    localparam logic [4:0] S_ZM_MUL   = 5'd17;
    localparam logic [4:0] S_ZM_APPLY = 5'd18;
    localparam logic [4:0] S_OUT      = 5'd20;

    localparam logic [2:0] J_TICK    = 3'd0;
    localparam logic [2:0] J_SET     = 3'd1;
    localparam logic [2:0] J_DIR     = 3'd2;
    localparam logic [2:0] J_ZOOM    = 3'd3;
    localparam logic [2:0] J_REFRESH = 3'd4;
    localparam logic [2:0] J_OUT     = 3'd5;

    // floor(a / 10) equals (a * RECIP_10) >> 35 for every 32-bit a.
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

    typedef struct packed {
        logic [2:0] kind;
        logic       pt;
    } job_t;

    // Job list of each command, walked by the phase counter.
    function automatic job_t job_of(input logic [2:0] op, input logic keep,
                                    input logic [2:0] ph);
        job_t j;
        j = '{kind: J_OUT, pt: PT_EYE};
        case (op)
            OP_TICK:
            begin
                case (ph)
                    3'd0:    j = '{kind: J_TICK, pt: PT_EYE};
                    3'd1:    j = '{kind: J_TICK, pt: PT_AIM};
                    default: j = '{kind: J_OUT, pt: PT_EYE};
                endcase
            end
            OP_SET_EYE, OP_SET_AIM:
            begin
                case (ph)
                    3'd0:    j = '{kind: J_SET, pt: (op == OP_SET_AIM)};
                    3'd1:    j = '{kind: J_DIR, pt: (op == OP_SET_AIM)};
                    3'd2:    j = keep ? '{kind: J_SET, pt: (op == OP_SET_EYE)}
                                      : '{kind: J_REFRESH, pt: PT_EYE};
                    3'd3:    j = keep ? '{kind: J_DIR, pt: (op == OP_SET_EYE)}
                                      : '{kind: J_OUT, pt: PT_EYE};
                    3'd4:    j = keep ? '{kind: J_REFRESH, pt: PT_EYE}
                                      : '{kind: J_OUT, pt: PT_EYE};
                    default: j = '{kind: J_OUT, pt: PT_EYE};
                endcase
            end
            OP_ZOOM_IN, OP_ZOOM_OUT:
            begin
                case (ph)
                    3'd0:    j = '{kind: J_ZOOM, pt: PT_EYE};
                    3'd1:    j = '{kind: J_SET, pt: PT_EYE};
                    3'd2:    j = '{kind: J_DIR, pt: PT_EYE};
                    3'd3:    j = '{kind: J_REFRESH, pt: PT_EYE};
                    default: j = '{kind: J_OUT, pt: PT_EYE};
                endcase
            end
            default: j = '{kind: J_OUT, pt: PT_EYE};
        endcase
        return j;
    endfunction

    logic [4:0]            state_reg, state_next;
    logic [2:0]            ph_reg, ph_next;
    logic [2:0]            job_reg, job_next;
    logic                  pt_reg, pt_next;
    logic [1:0]            comp_reg, comp_next;
    logic [1:0]            shift_reg, shift_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [1:0][2:0][31:0] now_reg, now_next;
    logic [1:0][2:0][31:0] goal_reg, goal_next;
    logic [1:0][2:0][15:0] dir_reg, dir_next;
    logic [1:0][31:0]      speed_reg, speed_next;
    logic [1:0]            busy_reg, busy_next;
    logic [2:0][31:0]      off_reg, off_next;
    logic [63:0]           prod_reg, acc_reg, acc_next;
    logic [33:0]           len_reg, len_next;
    logic [31:0]           dv_reg, dv_next;
    logic [31:0]           step_reg, step_next;
    logic                  brk_reg, brk_next;
    logic                  res_valid_reg, res_valid_next;
    res_t                  res_reg, res_next;

    logic [1:0]            cidx;
    logic [2:0][32:0]      diff_all;
    logic [2:0][32:0]      abs_all;
    logic [2:0][31:0]      coord_arr;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           mul_p;
    logic                  div_start, div_done;
    logic [63:0]           div_num, div_quo;
    logic [33:0]           div_den;
    logic                  sqrt_start, sqrt_done;
    logic [31:0]           sqrt_root;
    job_t                  job;
    logic [32:0]           v_sum;
    logic [31:0]           v_cur, v_new;
    logic [31:0]           step_now;
    logic [32:0]           mag;
    logic [34:0]           move_sum;
    logic [15:0]           dir_mag, dir_clamp;
    logic [31:0]           zm_abs;
    logic [31:0]           zm_num;
    logic [31:0]           zm_q;
    logic [32:0]           zm_mag;
    logic [34:0]           zm_val;

    assign coord_arr[0] = cmd_reg.coord_x;
    assign coord_arr[1] = cmd_reg.coord_y;
    assign coord_arr[2] = cmd_reg.coord_z;
    assign cidx = (comp_reg == 2'd3) ? 2'd0 : comp_reg;
    assign job  = job_of(cmd_reg.op, cmd_reg.keep_offset, ph_reg);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_all[k] = 33'($signed({goal_reg[pt_reg][k][31], goal_reg[pt_reg][k]})
                        - $signed({now_reg[pt_reg][k][31], now_reg[pt_reg][k]}));
            abs_all[k]  = diff_all[k][32] ? 33'(-diff_all[k]) : diff_all[k];
        end
    end

    // The one multiplier; its product is always registered.
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        dir_mag = dir_reg[pt_reg][cidx][15] ? 16'(-dir_reg[pt_reg][cidx])
                                            : dir_reg[pt_reg][cidx];
        zm_abs  = off_reg[cidx][31] ? 32'(-off_reg[cidx]) : off_reg[cidx];
        // Zoom in needs ceil(a / 10), which is floor((a + 9) / 10).
        zm_num  = (cmd_reg.op == OP_ZOOM_IN) ? 32'(zm_abs + 32'd9) : zm_abs;
        case (state_reg)
            S_LEN_SQ:
            begin
                mul_a = 32'(abs_all[cidx] >> shift_reg);
                mul_b = 32'(abs_all[cidx] >> shift_reg);
            end
            S_TK_DV:
            begin
                mul_a = accel;
                mul_b = {16'd0, cmd_reg.dt};
            end
            S_TK_VV:
            begin
                mul_a = speed_reg[pt_reg];
                mul_b = speed_reg[pt_reg];
            end
            S_TK_STEP:
            begin
                mul_a = speed_reg[pt_reg];
                mul_b = {16'd0, cmd_reg.dt};
            end
            S_TK_MUL:
            begin
                mul_a = {16'd0, dir_mag};
                mul_b = step_reg;
            end
            S_ZM_MUL:
            begin
                mul_a = zm_num;
                mul_b = RECIP_10;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_num = prod_reg;
        div_den = {1'b0, accel, 1'b0};
        if (state_reg == S_DIR_CALC)
        begin
            div_num = {17'd0, abs_all[cidx], 14'd0};
            div_den = len_reg;
        end
    end

    assign div_start  = ((state_reg == S_TK_DIV) && (accel != 32'd0))
                     || ((state_reg == S_DIR_CALC) && (len_reg != 34'd0));
    assign sqrt_start = (state_reg == S_LEN_ROOT);

    tpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    tpm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        v_cur     = speed_reg[pt_reg];
        v_sum     = {1'b0, v_cur} + {1'b0, dv_reg};
        if (brk_reg)
        begin
            v_new = (v_sum < {1'b0, speed_limit}) ? v_sum[31:0] : speed_limit;
        end else
        begin
            v_new = (v_cur > dv_reg) ? 32'(v_cur - dv_reg) : 32'd0;
        end
        step_now  = prod_reg[47:16];
        mag       = prod_reg[46:14];
        move_sum  = dir_reg[pt_reg][cidx][15]
                  ? 35'(sext35(now_reg[pt_reg][cidx]) - {2'b00, mag})
                  : 35'(sext35(now_reg[pt_reg][cidx]) + {2'b00, mag});
        dir_clamp = (div_quo > {48'd0, DIR_ONE}) ? DIR_ONE : div_quo[15:0];
        // Nine tenths is a - ceil(a / 10); eleven tenths is a + floor(a / 10).
        zm_q      = {3'd0, prod_reg[63:35]};
        zm_mag    = (cmd_reg.op == OP_ZOOM_IN) ? 33'({1'b0, zm_abs} - {1'b0, zm_q})
                                               : 33'({1'b0, zm_abs} + {1'b0, zm_q});
        zm_val    = off_reg[cidx][31] ? 35'(-{2'b00, zm_mag})
                                      : {2'b00, zm_mag};
    end

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        job_next       = job_reg;
        pt_next        = pt_reg;
        comp_next      = comp_reg;
        shift_next     = shift_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        goal_next      = goal_reg;
        dir_next       = dir_reg;
        speed_next     = speed_reg;
        busy_next      = busy_reg;
        off_next       = off_reg;
        acc_next       = acc_reg;
        len_next       = len_reg;
        dv_next        = dv_reg;
        step_next      = step_reg;
        brk_next       = brk_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    ph_next    = '0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                ph_next  = ph_reg + 3'd1;
                job_next = job.kind;
                pt_next  = job.pt;
                case (job.kind)
                    J_TICK:
                    begin
                        if (busy_reg[job.pt])
                        begin
                            state_next = S_LEN_SHIFT;
                        end
                    end
                    J_SET:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (job.pt == PT_EYE)
                            begin
                                goal_next[PT_EYE][k] = (cmd_reg.op == OP_SET_EYE)
                                    ? coord_arr[k]
                                    : sat32(35'(sext35(goal_reg[PT_AIM][k])
                                              - sext35(off_reg[k])));
                            end else
                            begin
                                goal_next[PT_AIM][k] = (cmd_reg.op == OP_SET_AIM)
                                    ? coord_arr[k]
                                    : sat32(35'(sext35(goal_reg[PT_EYE][k])
                                              + sext35(off_reg[k])));
                            end
                        end
                        busy_next[job.pt] = 1'b1;
                    end
                    J_DIR:
                    begin
                        state_next = S_LEN_SHIFT;
                    end
                    J_ZOOM:
                    begin
                        comp_next  = '0;
                        state_next = S_ZM_MUL;
                    end
                    J_REFRESH:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            off_next[k] = sat32(35'(sext35(goal_reg[PT_AIM][k])
                                                  - sext35(goal_reg[PT_EYE][k])));
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_LEN_SHIFT:
            begin
                if (abs_all[0][32] || abs_all[1][32] || abs_all[2][32])
                begin
                    shift_next = 2'd2;
                end else if (abs_all[0][31] || abs_all[1][31] || abs_all[2][31])
                begin
                    shift_next = 2'd1;
                end else
                begin
                    shift_next = 2'd0;
                end
                acc_next   = '0;
                comp_next  = '0;
                state_next = S_LEN_SQ;
            end
            S_LEN_SQ:
            begin
                acc_next  = acc_reg + prod_reg;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd3)
                begin
                    state_next = S_LEN_ROOT;
                end
            end
            S_LEN_ROOT:
            begin
                state_next = S_LEN_WAIT;
            end
            S_LEN_WAIT:
            begin
                if (sqrt_done)
                begin
                    len_next  = 34'({2'b00, sqrt_root} << shift_reg);
                    comp_next = '0;
                    state_next = (job_reg == J_TICK) ? S_TK_DV : S_DIR_CALC;
                end
            end
            S_TK_DV:
            begin
                state_next = S_TK_VV;
            end
            S_TK_VV:
            begin
                dv_next    = prod_reg[47:16];
                state_next = S_TK_DIV;
            end
            S_TK_DIV:
            begin
                if (accel == 32'd0)
                begin
                    brk_next   = 1'b0;
                    state_next = S_TK_SPEED;
                end else
                begin
                    state_next = S_TK_DIVW;
                end
            end
            S_TK_DIVW:
            begin
                if (div_done)
                begin
                    brk_next   = {30'd0, len_reg} > div_quo;
                    state_next = S_TK_SPEED;
                end
            end
            S_TK_SPEED:
            begin
                speed_next[pt_reg] = v_new;
                state_next = S_TK_STEP;
            end
            S_TK_STEP:
            begin
                state_next = S_TK_SNAP;
            end
            S_TK_SNAP:
            begin
                step_next = step_now;
                comp_next = '0;
                if (len_reg <= {2'b00, step_now})
                begin
                    now_next[pt_reg]  = goal_reg[pt_reg];
                    busy_next[pt_reg] = 1'b0;
                    state_next = S_DISPATCH;
                end else
                begin
                    state_next = S_TK_MUL;
                end
            end
            S_TK_MUL:
            begin
                state_next = S_TK_ADD;
            end
            S_TK_ADD:
            begin
                now_next[pt_reg][cidx] = sat32(move_sum);
                comp_next = comp_reg + 2'd1;
                state_next = (comp_reg == 2'd2) ? S_DISPATCH : S_TK_MUL;
            end
            S_DIR_CALC:
            begin
                if (len_reg == 34'd0)
                begin
                    dir_next[pt_reg][cidx] = '0;
                    comp_next  = comp_reg + 2'd1;
                    state_next = (comp_reg == 2'd2) ? S_DISPATCH : S_DIR_CALC;
                end else
                begin
                    state_next = S_DIR_WAIT;
                end
            end
            S_DIR_WAIT:
            begin
                if (div_done)
                begin
                    dir_next[pt_reg][cidx] = diff_all[cidx][32] ? 16'(-dir_clamp)
                                                                : dir_clamp;
                    comp_next  = comp_reg + 2'd1;
                    state_next = (comp_reg == 2'd2) ? S_DISPATCH : S_DIR_CALC;
                end
            end
            S_ZM_MUL:
            begin
                state_next = S_ZM_APPLY;
            end
            S_ZM_APPLY:
            begin
                off_next[cidx] = sat32(zm_val);
                comp_next  = comp_reg + 2'd1;
                state_next = (comp_reg == 2'd2) ? S_DISPATCH : S_ZM_MUL;
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.eye_x  = now_reg[PT_EYE][0];
                    res_next.eye_y  = now_reg[PT_EYE][1];
                    res_next.eye_z  = now_reg[PT_EYE][2];
                    res_next.aim_x  = now_reg[PT_AIM][0];
                    res_next.aim_y  = now_reg[PT_AIM][1];
                    res_next.aim_z  = now_reg[PT_AIM][2];
                    res_next.moving = busy_reg[PT_EYE] | busy_reg[PT_AIM];
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= '0;
            job_reg       <= J_OUT;
            pt_reg        <= PT_EYE;
            comp_reg      <= '0;
            shift_reg     <= '0;
            brk_reg       <= 1'b0;
            now_reg       <= '0;
            goal_reg      <= '0;
            dir_reg       <= '0;
            speed_reg     <= '0;
            busy_reg      <= '0;
            off_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            job_reg       <= job_next;
            pt_reg        <= pt_next;
            comp_reg      <= comp_next;
            shift_reg     <= shift_next;
            brk_reg       <= brk_next;
            now_reg       <= now_next;
            goal_reg      <= goal_next;
            dir_reg       <= dir_next;
            speed_reg     <= speed_next;
            busy_reg      <= busy_next;
            off_reg       <= off_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        prod_reg <= mul_p;
        acc_reg  <= acc_next;
        len_reg  <= len_next;
        dv_reg   <= dv_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[src/trapezoidal_point_mover_3d_top.sv]
// Top level of the trapezoidal point mover: register port and motion core.
// Depends on tpm_pkg and tpm_core (which holds tpm_div and tpm_sqrt).
//
//   Channel  Signals                               Direction  Transfer when
//   cmd      cmd_valid, cmd_ready, cmd (cmd_t)     in         cmd_valid & cmd_ready
//   res      res_valid, res_ready, res (res_t)     out        res_valid & res_ready
//   apb      psel, penable, pwrite, paddr, pwdata  in         psel & penable & pwrite
//            prdata, pready                        out        (pready is always high)
//
// Every command returns exactly one result transfer. A tick runs, for each point
// still moving, a 32-step square root, a 64-step divide for the braking distance
// (skipped when accel is zero) and a few multiplies on the shared multiplier. A
// goal command runs, for each goal it sets, a square root and three 64-step
// divides; zoom adds three reciprocal multiplies. The shared divider does most
// of this work. Reset is asynchronous and clears all motion state at once. The
// next command is taken while a result still waits in the output register; only
// the final write of a result waits for res_ready.
`default_nettype none

module trapezoidal_point_mover_3d_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire tpm_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_ready,
    output tpm_pkg::res_t      res
);
    import tpm_pkg::*;

    logic [31:0] accel_reg, accel_next;
    logic [31:0] limit_reg, limit_next;
    logic        wr_en;

    // A register write lands in the access phase; the port never stalls.
    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        accel_next = accel_reg;
        limit_next = limit_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_ACCEL:       accel_next = pwdata;
                REG_SPEED_LIMIT: limit_next = pwdata;
                default:         accel_next = accel_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= ACCEL_RESET;
            limit_reg <= SPEED_LIMIT_RESET;
        end else
        begin
            accel_reg <= accel_next;
            limit_reg <= limit_next;
        end
    end

    assign prdata = (paddr[2] == REG_SPEED_LIMIT) ? limit_reg : accel_reg;
    assign pready = 1'b1;

    // The core holds the motion state and walks each command through the
    // shared multiplier, divider and square root under its sequencer.
    tpm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accel       (accel_reg),
        .speed_limit (limit_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the trapezoidal point mover top level.
// Depends on tpm_pkg and trapezoidal_point_mover_3d_top, and through it on tpm_core, tpm_div and tpm_sqrt.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tpm_pkg::*;

    // Register byte addresses: every register is 32 bits wide, so the
    // register at list index i lies at 4*i.
    localparam logic [2:0] ADDR_ACCEL       = 3'd0;
    localparam logic [2:0] ADDR_SPEED_LIMIT = 3'd4;

    // A goal command with keep_offset, which sets both goals, is the slowest
    // command; this limit bounds the whole run with the receiver's longest
    // stall and the sender's longest gap.
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int DRAIN_CYCLES = 600;
    localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] I32_MIN = 32'h8000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_t        cmd = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_t        res;

    trapezoidal_point_mover_3d_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    always #5 clk = ~clk;

    // Mirror of the block's state, updated as each command is accepted.
    logic [31:0] mdl_accel;
    logic [31:0] mdl_limit;
    logic signed [31:0] eye_pos [3];
    logic signed [31:0] aim_pos [3];
    logic signed [31:0] eye_tgt [3];
    logic signed [31:0] aim_tgt [3];
    logic signed [31:0] eye_heading [3];
    logic signed [31:0] aim_heading [3];
    logic signed [31:0] gap_vec [3];
    logic [31:0] eye_vel;
    logic [31:0] aim_vel;
    logic eye_active;
    logic aim_active;

    cmd_t pending_cmds[$];
    res_t expected_poses[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   sent_count = 0;
    int   accepted_count = 0;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return I32_MAX;
        if (v < -longint'(64'd2147483648)) return I32_MIN;
        return v[31:0];
    endfunction

    function automatic longint unsigned int_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs_of(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // Euclidean length with the block's pre-shift for very long differences.
    function automatic longint unsigned span_len(input longint a, input longint b,
                                                 input longint c);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mc;
        longint unsigned acc;
        int sh;
        ma = abs_of(a);
        mb = abs_of(b);
        mc = abs_of(c);
        sh = 0;
        while (((ma >> sh) >= 64'h8000_0000) || ((mb >> sh) >= 64'h8000_0000) ||
               ((mc >> sh) >= 64'h8000_0000))
            sh++;
        acc = (ma >> sh) * (ma >> sh) + (mb >> sh) * (mb >> sh) + (mc >> sh) * (mc >> sh);
        return int_root(acc) << sh;
    endfunction

    task automatic aim_heading_calc(input logic signed [31:0] from [3],
                                    input logic signed [31:0] to [3],
                                    output logic signed [31:0] hd [3]);
        longint d [3];
        longint unsigned len;
        longint unsigned q;
        for (int i = 0; i < 3; i++) d[i] = longint'(to[i]) - longint'(from[i]);
        len = span_len(d[0], d[1], d[2]);
        for (int i = 0; i < 3; i++) begin
            q = 0;
            if (len != 0) q = (abs_of(d[i]) << DIR_FRAC) / len;
            if (q > (64'd1 << DIR_FRAC)) q = 64'd1 << DIR_FRAC;
            hd[i] = (d[i] < 0) ? 32'(-longint'(q)) : 32'(longint'(q));
        end
    endtask

    // One tick of the trapezoidal profile for one point.
    task automatic advance_point(inout logic signed [31:0] pos [3],
                                 input logic signed [31:0] tgt [3],
                                 input logic signed [31:0] hd [3],
                                 inout logic [31:0] vel, inout logic active,
                                 input logic [15:0] dt);
        longint d [3];
        longint unsigned remaining;
        longint unsigned v;
        longint unsigned dv;
        longint unsigned stride;
        longint mag;
        if (!active) return;
        for (int i = 0; i < 3; i++) d[i] = longint'(tgt[i]) - longint'(pos[i]);
        remaining = span_len(d[0], d[1], d[2]);
        v = vel;
        dv = (longint'(mdl_accel) * dt) >> DT_FRAC;
        if (mdl_accel != 0 && remaining > (v * v) / (64'd2 * mdl_accel)) begin
            if (v + dv < mdl_limit) v = v + dv;
            else v = mdl_limit;
        end else if (v > dv) begin
            v = v - dv;
        end else begin
            v = 0;
        end
        vel = v[31:0];
        stride = (v * dt) >> DT_FRAC;
        if (remaining <= stride) begin
            for (int i = 0; i < 3; i++) pos[i] = tgt[i];
            active = 1'b0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                mag = (abs_of(hd[i]) * stride) >> DIR_FRAC;
                pos[i] = clamp32(longint'(pos[i]) + ((hd[i] < 0) ? -mag : mag));
            end
        end
    endtask

    task automatic update_gap();
        for (int i = 0; i < 3; i++)
            gap_vec[i] = clamp32(longint'(aim_tgt[i]) - longint'(eye_tgt[i]));
    endtask

    task automatic retarget_eye(input longint c [3]);
        for (int i = 0; i < 3; i++) eye_tgt[i] = clamp32(c[i]);
        aim_heading_calc(eye_pos, eye_tgt, eye_heading);
        eye_active = 1'b1;
    endtask

    task automatic retarget_aim(input longint c [3]);
        for (int i = 0; i < 3; i++) aim_tgt[i] = clamp32(c[i]);
        aim_heading_calc(aim_pos, aim_tgt, aim_heading);
        aim_active = 1'b1;
    endtask

    task automatic eye_behind_aim();
        longint c [3];
        for (int i = 0; i < 3; i++) c[i] = longint'(aim_tgt[i]) - longint'(gap_vec[i]);
        retarget_eye(c);
        update_gap();
    endtask

    task automatic reset_mirror();
        mdl_accel = ACCEL_RESET;
        mdl_limit = SPEED_LIMIT_RESET;
        for (int i = 0; i < 3; i++) begin
            eye_pos[i] = 0; aim_pos[i] = 0; eye_tgt[i] = 0; aim_tgt[i] = 0;
            eye_heading[i] = 0; aim_heading[i] = 0; gap_vec[i] = 0;
        end
        eye_vel = 0; aim_vel = 0; eye_active = 0; aim_active = 0;
    endtask

    // Applies one accepted command and returns the pose the block must report.
    task automatic predict_pose(input cmd_t c, output res_t r);
        longint coords [3];
        longint t [3];
        coords[0] = c.coord_x; coords[1] = c.coord_y; coords[2] = c.coord_z;
        case (c.op)
            OP_TICK: begin
                advance_point(eye_pos, eye_tgt, eye_heading, eye_vel, eye_active, c.dt);
                advance_point(aim_pos, aim_tgt, aim_heading, aim_vel, aim_active, c.dt);
            end
            OP_SET_EYE: begin
                retarget_eye(coords);
                if (c.keep_offset) begin
                    for (int i = 0; i < 3; i++)
                        t[i] = longint'(eye_tgt[i]) + longint'(gap_vec[i]);
                    retarget_aim(t);
                end
                update_gap();
            end
            OP_SET_AIM: begin
                retarget_aim(coords);
                if (c.keep_offset) eye_behind_aim();
                else update_gap();
            end
            OP_ZOOM_IN, OP_ZOOM_OUT: begin
                for (int i = 0; i < 3; i++)
                    gap_vec[i] = clamp32((longint'(gap_vec[i]) *
                                          ((c.op == OP_ZOOM_IN) ? 9 : 11)) / 10);
                eye_behind_aim();
            end
            default: ;
        endcase
        r.eye_x = eye_pos[0]; r.eye_y = eye_pos[1]; r.eye_z = eye_pos[2];
        r.aim_x = aim_pos[0]; r.aim_y = aim_pos[1]; r.aim_z = aim_pos[2];
        r.moving = eye_active | aim_active;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Driver: bursts of transfers separated by random gaps. Valid holds until
    // the transfer happens, and the next command is loaded in the same step.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_valid && cmd_ready) begin
                res_t r;
                predict_pose(cmd, r);
                expected_poses.push_back(r);
                accepted_count++;
            end
            if (!cmd_valid || cmd_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cmd <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    sent_count++;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls follow a slowly changing pattern, including long
    // stretches with ready held high.
    int stall_mode = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= ($urandom_range(0, 1) == 0);
                2: res_ready <= ($urandom_range(0, 7) == 0);
                default: res_ready <= (cycle_count % 16) < 4;
            endcase
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge clk) begin
        cycle_count++;
        if (rst_n && res_valid && res_ready) begin
            if (expected_poses.size() == 0) begin
                report("unexpected result", '0, '0);
            end else begin
                res_t w;
                w = expected_poses.pop_front();
                if (res.eye_x !== w.eye_x) report("eye_x", res.eye_x, w.eye_x);
                if (res.eye_y !== w.eye_y) report("eye_y", res.eye_y, w.eye_y);
                if (res.eye_z !== w.eye_z) report("eye_z", res.eye_z, w.eye_z);
                if (res.aim_x !== w.aim_x) report("aim_x", res.aim_x, w.aim_x);
                if (res.aim_y !== w.aim_y) report("aim_y", res.aim_y, w.aim_y);
                if (res.aim_z !== w.aim_z) report("aim_z", res.aim_z, w.aim_z);
                if (res.moving !== w.moving)
                    report("moving", 32'(res.moving), 32'(w.moving));
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic cmd_t make_cmd(input logic [2:0] op, input logic [15:0] dt,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic keep);
        cmd_t c;
        c.op = op; c.dt = dt; c.coord_x = x; c.coord_y = y; c.coord_z = z;
        c.keep_offset = keep;
        return c;
    endfunction

    // Coordinates mostly near the origin so motion ends in reasonable time,
    // sometimes anywhere in the full range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return ($urandom_range(0, 1) == 0) ? I32_MAX : I32_MIN;
            default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        int pick;
        logic [15:0] dt;
        pick = $urandom_range(0, 99);
        dt = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(600, 8000));
        if (pick < 60)
            return make_cmd(OP_TICK, dt, $urandom(), $urandom(), $urandom(),
                            1'($urandom_range(0, 1)));
        if (pick < 75)
            return make_cmd(OP_SET_EYE, 16'($urandom()), rand_coord(), rand_coord(),
                            rand_coord(), 1'($urandom_range(0, 1)));
        if (pick < 90)
            return make_cmd(OP_SET_AIM, 16'($urandom()), rand_coord(), rand_coord(),
                            rand_coord(), 1'($urandom_range(0, 1)));
        if (pick < 94)
            return make_cmd(OP_ZOOM_IN, 16'($urandom()), $urandom(), $urandom(), $urandom(),
                            1'($urandom_range(0, 1)));
        if (pick < 98)
            return make_cmd(OP_ZOOM_OUT, 16'($urandom()), $urandom(), $urandom(), $urandom(),
                            1'($urandom_range(0, 1)));
        return make_cmd(3'($urandom_range(5, 7)), 16'($urandom()), $urandom(), $urandom(),
                        $urandom(), 1'($urandom_range(0, 1)));
    endfunction

    // Register write: a setup phase, then an access phase with pready high.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_ACCEL) mdl_accel = value;
        else mdl_limit = value;
    endtask

    // Waits until every result of the phase has come back, then lets the
    // block settle before its registers change.
    task automatic drain();
        while (pending_cmds.size() > 0 || cmd_valid || expected_poses.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) pending_cmds.push_back(rand_cmd());
    endtask

    initial begin
        reset_mirror();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: goal equal to position, the extreme corners with
        // long differences, keep_offset both ways, zooms, unused op codes and
        // a full-length tick.
        pending_cmds.push_back(make_cmd(OP_TICK, 16'hFFFF, '0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_SET_EYE, 16'hFFFF, '0, '0, '0, 1'b1));
        pending_cmds.push_back(make_cmd(OP_TICK, 16'd0, I32_MAX, I32_MIN, '1, 1'b1));
        pending_cmds.push_back(make_cmd(OP_SET_AIM, '0, 32'h0003_0000, 32'hFFFE_0000,
                                        32'h0001_8000, 1'b0));
        pending_cmds.push_back(make_cmd(OP_SET_EYE, '0, I32_MAX, I32_MIN, I32_MAX, 1'b0));
        pending_cmds.push_back(make_cmd(OP_SET_AIM, '0, I32_MIN, I32_MAX, I32_MIN, 1'b0));
        pending_cmds.push_back(make_cmd(OP_TICK, 16'hFFFF, '0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_SET_EYE, '0, 32'h0001_0000, '0, '0, 1'b1));
        pending_cmds.push_back(make_cmd(OP_SET_AIM, '0, '0, 32'h0002_0000, '0, 1'b1));
        pending_cmds.push_back(make_cmd(OP_ZOOM_IN, 16'hFFFF, '1, '1, '1, 1'b1));
        pending_cmds.push_back(make_cmd(OP_ZOOM_OUT, '0, '0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(3'd5, 16'hFFFF, '1, '1, '1, 1'b1));
        pending_cmds.push_back(make_cmd(3'd6, '0, '0, '0, '0, 1'b0));
        pending_cmds.push_back(make_cmd(3'd7, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                        32'hAAAA_AAAA, 1'b1));
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(make_cmd(OP_TICK, 16'h8000, '0, '0, '0, 1'b0));
        drain();

        // Phases of random traffic under different register settings,
        // including zero and full-scale acceleration and speed limits.
        queue_random(200);
        drain();
        apb_write(ADDR_ACCEL, 32'h0008_0000);
        apb_write(ADDR_SPEED_LIMIT, 32'h0001_0000);
        queue_random(150);
        drain();
        apb_write(ADDR_ACCEL, 32'd1);
        apb_write(ADDR_SPEED_LIMIT, 32'hFFFF_FFFF);
        queue_random(100);
        drain();
        apb_write(ADDR_ACCEL, 32'hFFFF_FFFF);
        apb_write(ADDR_SPEED_LIMIT, 32'd0);
        queue_random(80);
        drain();
        apb_write(ADDR_ACCEL, 32'd0);
        apb_write(ADDR_SPEED_LIMIT, 32'h0020_0000);
        queue_random(80);
        drain();
        apb_write(ADDR_ACCEL, 32'h0040_0000);
        apb_write(ADDR_SPEED_LIMIT, 32'h0080_0000);
        queue_random(220);
        drain();

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
